// ===== hdl/pfbs_pkg.sv =====
`default_nettype none

package pfbs_pkg;

    localparam int PACKET_BITS = 32;
    localparam int BIT_POS_W   = $clog2(PACKET_BITS);

    localparam logic       MODE_PUSH = 1'b0;
    localparam logic       MODE_PULL = 1'b1;

    localparam logic [7:0] ERR_BYTE0 = 8'd253;
    localparam logic [7:0] ERR_BYTE1 = 8'h03;
    localparam logic [7:0] ERR_BYTE3 = 8'h00;

    typedef logic [PACKET_BITS-1:0] t_packet;

endpackage

`default_nettype wire

// ===== hdl/pfbs_ram.sv =====
`default_nettype none

module pfbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_wr_en,
    input  wire [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire [WIDTH-1:0]         i_wr_data,
    input  wire                     i_rd_en,
    input  wire [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/packet_fifo_bit_serializer_top.sv =====
// results: a push, or a pull of a packet's 2nd..32nd bit, gives its result in the cycle after the
// request is taken; a pull of a packet's first bit first passes through the slot read state
// throughput: one request per cycle while the output is free or being taken; the first bit of
// a packet waits for the registered read port of the slot memory feeding the bit shift register
// reset (synchronous, active low) clears the pointers, the bit position and the output valid;
// the slot memory is not cleared, every slot is written before it is read
`default_nettype none

module packet_fifo_bit_serializer_top #(
    parameter int SLOT_COUNT = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_mode,
    input  wire  [31:0] i_packet_word,
    input  wire  [7:0]  i_rx_status,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_data_bit,
    output logic        o_bit_valid,
    output logic        o_packet_done,
    output logic        o_push_dropped,
    output logic        o_fifo_empty
);

    localparam int PTR_W = $clog2(SLOT_COUNT);
    localparam int BPW   = pfbs_pkg::BIT_POS_W;
    localparam int PB    = pfbs_pkg::PACKET_BITS;

    typedef enum logic {ST_IDLE, ST_LOAD} t_state;

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [BPW-1:0]     r_bit_pos, n_bit_pos;
    logic [PB-2:0]      r_shift, n_shift;
    logic               r_out_valid, n_out_valid;
    logic               r_data_bit, n_data_bit;
    logic               r_bit_valid, n_bit_valid;
    logic               r_packet_done, n_packet_done;
    logic               r_push_dropped, n_push_dropped;
    logic               r_fifo_empty, n_fifo_empty;

    logic               accept;
    logic               is_push;
    logic               full;
    logic               empty;
    logic [PTR_W-1:0]   wr_next;
    logic [PTR_W-1:0]   rd_next;
    logic               ram_wr_en;
    logic               ram_rd_en;
    pfbs_pkg::t_packet  ram_wr_data;
    pfbs_pkg::t_packet  ram_rd_data;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign is_push     = (i_mode == pfbs_pkg::MODE_PUSH);
    assign wr_next     = (r_wr_ptr == PTR_W'(SLOT_COUNT - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign rd_next     = (r_rd_ptr == PTR_W'(SLOT_COUNT - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign full        = (wr_next == r_rd_ptr);
    assign empty       = (r_rd_ptr == r_wr_ptr);
    assign ram_wr_en   = accept && is_push && !full;
    assign ram_rd_en   = accept && !is_push && !empty && (r_bit_pos == '0);
    assign ram_wr_data = (i_rx_status != 8'd0)
        ? {pfbs_pkg::ERR_BYTE3, i_rx_status, pfbs_pkg::ERR_BYTE1, pfbs_pkg::ERR_BYTE0}
        : i_packet_word;

    pfbs_ram #(
        .WIDTH (PB),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        n_state        = r_state;
        n_wr_ptr       = r_wr_ptr;
        n_rd_ptr       = r_rd_ptr;
        n_bit_pos      = r_bit_pos;
        n_shift        = r_shift;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_data_bit     = r_data_bit;
        n_bit_valid    = r_bit_valid;
        n_packet_done  = r_packet_done;
        n_push_dropped = r_push_dropped;
        n_fifo_empty   = r_fifo_empty;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (is_push) begin
                        n_out_valid    = 1'b1;
                        n_data_bit     = 1'b0;
                        n_bit_valid    = 1'b0;
                        n_packet_done  = 1'b0;
                        n_push_dropped = full;
                        if (full) begin
                            n_fifo_empty = empty;
                        end else begin
                            n_wr_ptr     = wr_next;
                            n_fifo_empty = (r_rd_ptr == wr_next);
                        end
                    end else if (empty) begin
                        n_out_valid    = 1'b1;
                        n_data_bit     = 1'b0;
                        n_bit_valid    = 1'b0;
                        n_packet_done  = 1'b0;
                        n_push_dropped = 1'b0;
                        n_fifo_empty   = 1'b1;
                    end else if (r_bit_pos == '0) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_out_valid    = 1'b1;
                        n_data_bit     = r_shift[0];
                        n_bit_valid    = 1'b1;
                        n_push_dropped = 1'b0;
                        n_shift        = r_shift >> 1;
                        n_bit_pos      = r_bit_pos + 1'b1;
                        n_packet_done  = (r_bit_pos == BPW'(PB - 1));
                        n_fifo_empty   = 1'b0;
                        if (r_bit_pos == BPW'(PB - 1)) begin
                            n_rd_ptr     = rd_next;
                            n_fifo_empty = (rd_next == r_wr_ptr);
                        end
                    end
                end
            end
            ST_LOAD: begin
                n_state        = ST_IDLE;
                n_out_valid    = 1'b1;
                n_data_bit     = ram_rd_data[0];
                n_bit_valid    = 1'b1;
                n_packet_done  = 1'b0;
                n_push_dropped = 1'b0;
                n_fifo_empty   = 1'b0;
                n_shift        = ram_rd_data[PB-1:1];
                n_bit_pos      = BPW'(1);
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_bit_pos   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_bit_pos   <= n_bit_pos;
            r_out_valid <= n_out_valid;
        end
        r_shift        <= n_shift;
        r_data_bit     <= n_data_bit;
        r_bit_valid    <= n_bit_valid;
        r_packet_done  <= n_packet_done;
        r_push_dropped <= n_push_dropped;
        r_fifo_empty   <= n_fifo_empty;
    end

    assign o_out_valid    = r_out_valid;
    assign o_data_bit     = r_data_bit;
    assign o_bit_valid    = r_bit_valid;
    assign o_packet_done  = r_packet_done;
    assign o_push_dropped = r_push_dropped;
    assign o_fifo_empty   = r_fifo_empty;

    // memory read only waits with the output register free
    a_load_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> !r_out_valid)
        else $error("result pending during slot read");

    a_load_gives_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |=> (r_out_valid && r_bit_valid && !r_packet_done
            && (r_bit_pos == BPW'(1))))
        else $error("first bit of packet not delivered after slot read");

    a_done_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_push && !empty && (r_bit_pos == BPW'(PB - 1)))
            |=> (r_rd_ptr != $past(r_rd_ptr)) && (r_bit_pos == '0) && r_packet_done)
        else $error("last bit did not advance read pointer");

    a_no_mixed_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_push_dropped && r_bit_valid) && (!r_packet_done || r_bit_valid))
        else $error("inconsistent result flags");

endmodule

`default_nettype wire
